### hw/rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin task scheduler package
// Shared widths, defaults and function codes for the scheduler block.
// ----------------------------------------------------------------------------
package rrts_pkg;

   // Configuration register
   localparam int CSR_W = 4;
   localparam logic [CSR_W-1:0] TASK_COUNT_RESET = 4'd1;

   // Transaction field widths
   localparam int DELAY_IN_W = 32;
   localparam int TASK_W     = 3;

   // Defaults for the top level parameters
   localparam int DEF_TASK_SLOTS = 8;
   localparam int DEF_DELAY_BITS = 32;

   // Request function codes
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_DELAY = 1'b1;

endpackage

### hw/rtl/rrts_req_if.sv
// ----------------------------------------------------------------------------
// Scheduler request channel
// Valid/ready channel carrying one tick or delay transaction.
// ----------------------------------------------------------------------------
interface rrts_req_if;
   logic                           valid;
   logic                           ready;
   logic                           func;
   logic [rrts_pkg::DELAY_IN_W-1:0] hold_ticks;

   modport source (output valid, output func, output hold_ticks, input ready);
   modport sink   (input valid, input func, input hold_ticks, output ready);
endinterface

### hw/rtl/rrts_rsp_if.sv
// ----------------------------------------------------------------------------
// Scheduler response channel
// Valid/ready channel carrying the switch decision for one transaction.
// ----------------------------------------------------------------------------
interface rrts_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       switch_request;
   logic [rrts_pkg::TASK_W-1:0] prev_task;
   logic [rrts_pkg::TASK_W-1:0] next_task;

   modport source (output valid, output switch_request, output prev_task,
                   output next_task, input ready);
   modport sink   (input valid, input switch_request, input prev_task,
                   input next_task, output ready);
endinterface

### hw/rtl/rrts_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rrts_ram #(
   parameter int WIDTH = rrts_pkg::DEF_DELAY_BITS,
   parameter int DEPTH = rrts_pkg::DEF_TASK_SLOTS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/round_robin_task_scheduler.sv
// ----------------------------------------------------------------------------
// Round-robin task scheduler
// Tick countdown of blocked tasks and round-robin pick of the next task.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch : one transaction per timer tick (func = 0) or per delay call of
//            the running task (func = 1, hold_ticks = ticks to block, zero
//            blocks for good). Accepted when valid and ready are both high.
//   rsp_ch : exactly one transaction per request: switch_request, the task
//            that ran before (prev_task) and the task that runs next.
//   csr_*  : task_count write (1..TASK_SLOTS, idle task is the last one);
//            write only while the block is idle.
// Timing: one request at a time; ready is low from acceptance until the
//   result moves to the output register. A tick sweeps the slots through
//   the delay RAM; the start slot takes one compare-subtract per cycle;
//   the pick checks one candidate per cycle. A delay skips the sweep.
// Reset: synchronous; task_count = 1, all tasks ready, task 0 running;
//   the delay RAM is not cleared, a count is only used while blocked.
// Stall: a finished result waits in the output register; the next request
//   is worked on and holds in its last step until the register frees up.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler #(
   parameter int TASK_SLOTS = rrts_pkg::DEF_TASK_SLOTS,
   parameter int DELAY_BITS = rrts_pkg::DEF_DELAY_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   rrts_req_if.sink                   req_ch,
   rrts_rsp_if.source                 rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [rrts_pkg::CSR_W-1:0] csr_wr_data
);
   import rrts_pkg::*;

   localparam int AW = $clog2(TASK_SLOTS);       // slot index
   localparam int IW = $clog2(TASK_SLOTS + 1);   // counts up to TASK_SLOTS
   localparam int NW = (IW > CSR_W) ? IW : CSR_W;

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TICK = 3'd1;  // countdown sweep over slots
   localparam logic [2:0] S_MOD  = 3'd2;  // start slot modulo task count
   localparam logic [2:0] S_PICK = 3'd3;  // round-robin search
   localparam logic [2:0] S_DONE = 3'd4;  // wait for output register

   logic [2:0]            state_ff, state_in;
   logic [CSR_W-1:0]      task_count_ff, task_count_in;
   logic [TASK_SLOTS-1:0] blocked_ff, blocked_in;
   logic [AW-1:0]         running_ff, running_in;
   logic                  func_ff, func_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic                  upd_vld_ff, upd_vld_in;
   logic [AW-1:0]         upd_idx_ff, upd_idx_in;
   logic [IW-1:0]         cand_ff, cand_in;
   logic                  res_sw_ff, res_sw_in;
   logic [AW-1:0]         res_prev_ff, res_prev_in;
   logic [AW-1:0]         res_next_ff, res_next_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_sw_ff, rsp_sw_in;
   logic [TASK_W-1:0]     rsp_prev_ff, rsp_prev_in;
   logic [TASK_W-1:0]     rsp_next_ff, rsp_next_in;

   // Delay RAM ports
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [DELAY_BITS-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;
   logic [DELAY_BITS-1:0] ram_rd_data;

   // Effective task count, clamped to 1..TASK_SLOTS
   logic [NW-1:0] cnt_wide;
   logic [IW-1:0] act_n;
   logic [IW-1:0] idle_wide;
   logic [AW-1:0] idle_slot;
   logic          req_acc;
   logic          out_free;

   always_comb begin
      cnt_wide = NW'(task_count_ff);
      if (cnt_wide == '0) begin
         cnt_wide = NW'(1);
      end else if (cnt_wide > NW'(TASK_SLOTS)) begin
         cnt_wide = NW'(TASK_SLOTS);
      end
   end

   assign act_n     = cnt_wide[IW-1:0];
   assign idle_wide = act_n - IW'(1);
   assign idle_slot = idle_wide[AW-1:0];

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign task_count_in = csr_wr_en ? csr_wr_data : task_count_ff;

   always_comb begin
      state_in    = state_ff;
      blocked_in  = blocked_ff;
      running_in  = running_ff;
      func_in     = func_ff;
      idx_in      = idx_ff;
      upd_vld_in  = 1'b0;
      upd_idx_in  = upd_idx_ff;
      cand_in     = cand_ff;
      res_sw_in   = res_sw_ff;
      res_prev_in = res_prev_ff;
      res_next_in = res_next_ff;
      rsp_sw_in   = rsp_sw_ff;
      rsp_prev_in = rsp_prev_ff;
      rsp_next_in = rsp_next_ff;
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = upd_idx_ff;
      ram_wr_data = ram_rd_data - DELAY_BITS'(1);
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               func_in = req_ch.func;
               if (req_ch.func == FUNC_TICK) begin
                  idx_in   = '0;
                  state_in = S_TICK;
               end else begin
                  // idle task never blocks
                  if (running_ff != idle_slot) begin
                     blocked_in[running_ff] = 1'b1;
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = running_ff;
                     ram_wr_data = req_ch.hold_ticks[DELAY_BITS-1:0];
                  end
                  cand_in  = IW'(running_ff) + IW'(1);
                  state_in = S_MOD;
               end
            end
         end
         S_TICK: begin
            // read slot idx while updating the slot read last cycle
            if (idx_ff < act_n) begin
               ram_rd_en  = 1'b1;
               upd_vld_in = 1'b1;
               upd_idx_in = idx_ff[AW-1:0];
               idx_in     = idx_ff + IW'(1);
            end
            if (upd_vld_ff && blocked_ff[upd_idx_ff] && (ram_rd_data != '0)) begin
               ram_wr_en = 1'b1;
               if (ram_rd_data == DELAY_BITS'(1)) begin
                  blocked_in[upd_idx_ff] = 1'b0;
               end
            end
            if (!upd_vld_ff && (idx_ff >= act_n)) begin
               cand_in  = IW'(running_ff) + IW'(1);
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (cand_ff >= act_n) begin
               cand_in = cand_ff - act_n;
            end else begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if ((cand_ff[AW-1:0] == idle_slot) || !blocked_ff[cand_ff[AW-1:0]]) begin
               res_prev_in = running_ff;
               res_next_in = cand_ff[AW-1:0];
               res_sw_in   = (func_ff == FUNC_DELAY) || (cand_ff[AW-1:0] != running_ff);
               running_in  = cand_ff[AW-1:0];
               state_in    = S_DONE;
            end else if (cand_ff + IW'(1) == act_n) begin
               cand_in = '0;
            end else begin
               cand_in = cand_ff + IW'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sw_in    = res_sw_ff;
               rsp_prev_in  = TASK_W'(res_prev_ff);
               rsp_next_in  = TASK_W'(res_next_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         task_count_ff <= TASK_COUNT_RESET;
         blocked_ff    <= '0;
         running_ff    <= '0;
         upd_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         task_count_ff <= task_count_in;
         blocked_ff    <= blocked_in;
         running_ff    <= running_in;
         upd_vld_ff    <= upd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      idx_ff      <= idx_in;
      upd_idx_ff  <= upd_idx_in;
      cand_ff     <= cand_in;
      res_sw_ff   <= res_sw_in;
      res_prev_ff <= res_prev_in;
      res_next_ff <= res_next_in;
      rsp_sw_ff   <= rsp_sw_in;
      rsp_prev_ff <= rsp_prev_in;
      rsp_next_ff <= rsp_next_in;
   end

   rrts_ram #(
      .WIDTH (DELAY_BITS),
      .DEPTH (TASK_SLOTS)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.switch_request = rsp_sw_ff;
   assign rsp_ch.prev_task      = rsp_prev_ff;
   assign rsp_ch.next_task      = rsp_next_ff;

`ifndef SYNTHESIS
   // one request in flight: ready drops right after acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ch.ready)
      else $error("request accepted while another is in flight");

   // no switch request means the task stays the same
   a_no_switch_same_task: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_sw_ff) |-> (rsp_prev_ff == rsp_next_ff))
      else $error("task changed without a switch request");

   // countdown pipeline only runs during the tick sweep
   a_sweep_in_tick: assert property (@(posedge clock) disable iff (reset)
      upd_vld_ff |-> (state_ff == S_TICK))
      else $error("countdown update outside tick sweep");

   // a picked task is the idle task or a ready one
   a_pick_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PICK && state_in == S_DONE) |=>
         ((running_ff == idle_slot) || !blocked_ff[running_ff]))
      else $error("blocked task picked to run");
`endif

endmodule
